// ----- design/sdq_pkg.sv -----
`default_nettype none

package sdq_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_TASKS  = 32;
    localparam int DEF_DELAY_BITS = 32;

    // fixed port widths
    localparam int TASK_ID_W = 5;
    localparam int TICKS_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int HDELTA_W  = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE       = 2'd0,
        STAT_DUP_INSERT = 2'd1,
        STAT_ABSENT     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINK1,
        S_LINK2,
        S_RM_NX,
        S_RM_WR,
        S_FIN
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_ins;
        logic    load_rm;
        logic    walk;
        logic    link1;
        logic    link2;
        logic    rm_nx;
        logic    rm_wr;
        logic    out_load;
        status_t status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic id_ok;
        logic queued;
        logic nonempty;
        logic walk_ge;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/sdq_ram.sv -----
`default_nettype none

module sdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/sdq_ctrl.sv -----
`default_nettype none

module sdq_ctrl
    import sdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     command,
    input  wire dp_stat_t st,
    output logic          in_ready,
    output dp_cmd_t       cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= STAT_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = STAT_DONE;
                    priority if (!st.id_ok)
                    begin
                        status_next = STAT_ABSENT;
                        state_next  = S_FIN;
                    end
                    else if (command == CMD_INSERT)
                    begin
                        if (st.queued)
                        begin
                            status_next = STAT_DUP_INSERT;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = st.nonempty ? S_WALK : S_LINK1;
                        end
                    end
                    else
                    begin
                        if (!st.queued)
                        begin
                            status_next = STAT_ABSENT;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_RM_NX;
                        end
                    end
                end
            end
            S_WALK:
            begin
                if (!st.walk_ge || st.walk_last)
                begin
                    state_next = S_LINK1;
                end
            end
            S_LINK1: state_next = S_LINK2;
            S_LINK2: state_next = S_FIN;
            S_RM_NX: state_next = S_RM_WR;
            S_RM_WR: state_next = S_FIN;
            S_FIN:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && st.id_ok)
                begin
                    cmd.load_ins = (command == CMD_INSERT) && !st.queued;
                    cmd.load_rm  = (command == CMD_REMOVE) && st.queued;
                end
            end
            S_WALK:  cmd.walk  = 1'b1;
            S_LINK1: cmd.link1 = 1'b1;
            S_LINK2: cmd.link2 = 1'b1;
            S_RM_NX: cmd.rm_nx = 1'b1;
            S_RM_WR: cmd.rm_wr = 1'b1;
            S_FIN:   cmd.out_load = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/sdq_dp.sv -----
`default_nettype none

module sdq_dp
    import sdq_pkg::*;
#(
    parameter int MAX_TASKS  = DEF_MAX_TASKS,
    parameter int DELAY_BITS = DEF_DELAY_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    input  wire logic [TASK_ID_W-1:0] task_id,
    input  wire logic [TICKS_W-1:0]   ticks,
    input  wire logic                 out_ready,
    output dp_stat_t                  st,
    output logic                      out_valid,
    output logic [STATUS_W-1:0]       status,
    output logic                      head_valid,
    output logic [TASK_ID_W-1:0]      head_task,
    output logic [HDELTA_W-1:0]       head_delta
);

    localparam int ID_W = $clog2(MAX_TASKS);
    localparam int LW   = ID_W + 1;   // top bit set = no link
    localparam int DW   = DELAY_BITS;
    localparam logic [LW-1:0] LINK_NONE = {1'b1, {ID_W{1'b0}}};

    logic [ID_W-1:0]      in_id;
    logic [ID_W-1:0]      raddr;
    logic [LW-1:0]        rd_next, rd_prev;
    logic [DW-1:0]        rd_delay;

    logic                 next_we, prev_we, dly_we;
    logic [ID_W-1:0]      next_waddr, prev_waddr, dly_waddr;
    logic [LW-1:0]        next_wdata, prev_wdata;
    logic [DW-1:0]        dly_wdata;

    // control state
    logic                 nonempty_reg, nonempty_next;
    logic [MAX_TASKS-1:0] mark_reg, mark_next;
    logic [ID_W-1:0]      head_reg, head_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [ID_W-1:0]      id_reg, id_next;
    logic [DW-1:0]        delay_reg, delay_next;     // remaining delay of new task
    logic [LW-1:0]        cur_reg, cur_next;         // insert: cur; remove: successor
    logic [LW-1:0]        before_reg, before_next;   // insert: before; remove: predecessor
    logic [DW-1:0]        dcur_reg, dcur_next;       // insert: delta of cur; remove: own delta
    logic [DW-1:0]        hd_reg, hd_next;
    logic [STATUS_W-1:0]  ostat_reg, ostat_next;
    logic                 ohv_reg, ohv_next;
    logic [TASK_ID_W-1:0] otask_reg, otask_next;
    logic [HDELTA_W-1:0]  odelta_reg, odelta_next;

    logic                 ge;
    logic [DW-1:0]        rm_sum;

    assign in_id  = ID_W'(task_id);
    assign ge     = delay_reg >= rd_delay;
    assign rm_sum = rd_delay + dcur_reg;

    assign st.id_ok     = int'(task_id) < MAX_TASKS;
    assign st.queued    = mark_reg[in_id];
    assign st.nonempty  = nonempty_reg;
    assign st.walk_ge   = ge;
    assign st.walk_last = rd_next[ID_W];
    assign st.out_free  = !out_valid_reg || out_ready;

    sdq_ram #(.WIDTH(LW), .DEPTH(MAX_TASKS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (raddr),
        .rdata (rd_next)
    );

    sdq_ram #(.WIDTH(LW), .DEPTH(MAX_TASKS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (raddr),
        .rdata (rd_prev)
    );

    sdq_ram #(.WIDTH(DW), .DEPTH(MAX_TASKS)) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (raddr),
        .rdata (rd_delay)
    );

    // read address
    always_comb
    begin
        priority if (cmd.load_ins)
        begin
            raddr = head_reg;
        end
        else if (cmd.load_rm)
        begin
            raddr = in_id;
        end
        else if (cmd.walk || cmd.rm_nx)
        begin
            raddr = rd_next[ID_W-1:0];
        end
        else
        begin
            raddr = id_reg;
        end
    end

    // write ports
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = id_reg;
        next_wdata = cur_reg;
        prev_we    = 1'b0;
        prev_waddr = id_reg;
        prev_wdata = before_reg;
        dly_we     = 1'b0;
        dly_waddr  = id_reg;
        dly_wdata  = delay_reg;
        priority if (cmd.link1)
        begin
            next_we = 1'b1;
            prev_we = 1'b1;
            dly_we  = 1'b1;
        end
        else if (cmd.link2)
        begin
            next_we    = !before_reg[ID_W];
            next_waddr = before_reg[ID_W-1:0];
            next_wdata = {1'b0, id_reg};
            prev_we    = !cur_reg[ID_W];
            prev_waddr = cur_reg[ID_W-1:0];
            prev_wdata = {1'b0, id_reg};
            dly_we     = !cur_reg[ID_W];
            dly_waddr  = cur_reg[ID_W-1:0];
            dly_wdata  = dcur_reg - delay_reg;
        end
        else if (cmd.rm_wr)
        begin
            next_we    = !before_reg[ID_W];
            next_waddr = before_reg[ID_W-1:0];
            next_wdata = cur_reg;
            prev_we    = !cur_reg[ID_W];
            prev_waddr = cur_reg[ID_W-1:0];
            prev_wdata = before_reg;
            dly_we     = !cur_reg[ID_W];
            dly_waddr  = cur_reg[ID_W-1:0];
            dly_wdata  = rm_sum;
        end
        else
        begin
            next_we = 1'b0;
        end
    end

    // register updates
    always_comb
    begin
        nonempty_next  = nonempty_reg;
        mark_next      = mark_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg;
        id_next        = id_reg;
        delay_next     = delay_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        dcur_next      = dcur_reg;
        hd_next        = hd_reg;
        ostat_next     = ostat_reg;
        ohv_next       = ohv_reg;
        otask_next     = otask_reg;
        odelta_next    = odelta_reg;

        if (cmd.load_ins)
        begin
            id_next     = in_id;
            delay_next  = DW'(ticks);
            cur_next    = nonempty_reg ? {1'b0, head_reg} : LINK_NONE;
            before_next = LINK_NONE;
        end

        if (cmd.load_rm)
        begin
            id_next = in_id;
        end

        if (cmd.walk)
        begin
            if (ge)
            begin
                delay_next  = delay_reg - rd_delay;
                before_next = cur_reg;
                cur_next    = rd_next;
            end
            else
            begin
                dcur_next = rd_delay;
            end
        end

        if (cmd.link1)
        begin
            mark_next[id_reg] = 1'b1;
            nonempty_next     = 1'b1;
            if (before_reg[ID_W])
            begin
                head_next = id_reg;
                hd_next   = delay_reg;
            end
        end

        if (cmd.rm_nx)
        begin
            cur_next    = rd_next;
            before_next = rd_prev;
            dcur_next   = rd_delay;
        end

        if (cmd.rm_wr)
        begin
            mark_next[id_reg] = 1'b0;
            if (before_reg[ID_W])
            begin
                if (cur_reg[ID_W])
                begin
                    nonempty_next = 1'b0;
                    head_next     = '0;
                end
                else
                begin
                    head_next = cur_reg[ID_W-1:0];
                    hd_next   = rm_sum;
                end
            end
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            ostat_next     = cmd.status;
            ohv_next       = nonempty_reg;
            otask_next     = nonempty_reg ? TASK_ID_W'(head_reg) : '0;
            odelta_next    = nonempty_reg ? HDELTA_W'(hd_reg) : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg  <= 1'b0;
            mark_reg      <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nonempty_reg  <= nonempty_next;
            mark_reg      <= mark_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        delay_reg  <= delay_next;
        cur_reg    <= cur_next;
        before_reg <= before_next;
        dcur_reg   <= dcur_next;
        hd_reg     <= hd_next;
        ostat_reg  <= ostat_next;
        ohv_reg    <= ohv_next;
        otask_reg  <= otask_next;
        odelta_reg <= odelta_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = ostat_reg;
    assign head_valid = ohv_reg;
    assign head_task  = otask_reg;
    assign head_delta = odelta_reg;

endmodule

`default_nettype wire

// ----- design/sleep_delta_queue_core.sv -----
// Insert: delta walk if the list is non-empty (at most to its tail), LINK1, LINK2;
//   remove RM_NX, RM_WR; flagged (duplicate, absent, bad task number) straight to FIN.
// Throughput: one item at a time; the delta walk reads one list entry per cycle
//   through the registered read port of the link and delay memories.
// A new item is accepted while the previous result waits in the output register.
// Reset (async, active low): list empty, all queued marks clear, no result pending.
`default_nettype none

module sleep_delta_queue_core
    import sdq_pkg::*;
#(
    parameter int MAX_TASKS  = DEF_MAX_TASKS,
    parameter int DELAY_BITS = DEF_DELAY_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 command,
    input  wire logic [TASK_ID_W-1:0] task_id,
    input  wire logic [TICKS_W-1:0]   ticks,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic                      head_valid,
    output logic [TASK_ID_W-1:0]      head_task,
    output logic [HDELTA_W-1:0]       head_delta
);

    dp_cmd_t  cmd;
    dp_stat_t st;

    // Controller: decodes the item, sequences walk / link / unlink, hands the
    // result to the output register once it is free.
    sdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Datapath: next/prev link memories, delta memory, queued marks,
    // head tracking and the result register.
    sdq_dp #(
        .MAX_TASKS  (MAX_TASKS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .task_id    (task_id),
        .ticks      (ticks),
        .out_ready  (out_ready),
        .st         (st),
        .out_valid  (out_valid),
        .status     (status),
        .head_valid (head_valid),
        .head_task  (head_task),
        .head_delta (head_delta)
    );

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item still in work");

    // the walk only runs over a non-empty list
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> st.nonempty)
        else $error("delta walk on empty list");

    // result only loaded into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("result overwrote pending item");

    // an empty list reports zero head fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> head_task == '0 && head_delta == '0)
        else $error("empty list with nonzero head fields");

endmodule

`default_nettype wire

// ----- tb/sv/sleep_delta_queue_core_tb.sv -----
`default_nettype none

module sleep_delta_queue_core_tb;
    import sdq_pkg::*;

    localparam int NTASK           = DEF_MAX_TASKS;
    localparam int NO_LINK         = NTASK;   // link code for "no neighbor"
    localparam int HOLD_OFF_CYCLES = 300;     // long receiver stall, fills the block
    localparam int WATCHDOG_LIMIT  = 4000;    // cycles with no handshake on either side
    localparam int TAIL_CYCLES     = 60;      // quiet time after the last result

    // one head report per item, as the block should produce it
    typedef struct {
        status_t                status;
        logic                   head_valid;
        logic [TASK_ID_W-1:0]   head_task;
        logic [HDELTA_W-1:0]    head_delta;
    } head_report_t;

    // ------------------------------------------------------------------
    // clock, reset, block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 command   = CMD_INSERT;
    logic [TASK_ID_W-1:0] task_id   = '0;
    logic [TICKS_W-1:0]   ticks     = '0;
    logic                 out_ready = 1'b0;

    logic                 in_ready;
    logic                 out_valid;
    logic [STATUS_W-1:0]  status;
    logic                 head_valid;
    logic [TASK_ID_W-1:0] head_task;
    logic [HDELTA_W-1:0]  head_delta;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sleep_delta_queue_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .task_id    (task_id),
        .ticks      (ticks),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .head_valid (head_valid),
        .head_task  (head_task),
        .head_delta (head_delta)
    );

    // ------------------------------------------------------------------
    // shadow of the sleep list: doubly linked, each entry holds its delay
    // relative to the entry before it
    // ------------------------------------------------------------------
    int           link_next [NTASK];
    int           link_prev [NTASK];
    logic [31:0]  delta_of  [NTASK];
    bit           task_queued [NTASK];
    int           list_first;
    bit           list_busy;
    int           queued_count;

    head_report_t head_reports [$];   // expected reports, oldest first
    int           error_count;

    // stall controls
    bit sender_gaps_on;
    bit receiver_stalls_on;
    bit hold_off_req;

    // Apply one command to the shadow list and return the head report that
    // follows. Flagged commands (duplicate insert, absent remove) change nothing.
    function automatic head_report_t apply_sleep_cmd(logic cmd, logic [TASK_ID_W-1:0] id,
                                                     logic [TICKS_W-1:0] tk);
        head_report_t rpt;
        logic [31:0]  left;
        int           cur;
        int           bef;
        int           nx;
        int           pv;
        int           walked;

        rpt.status = STAT_DONE;
        if (cmd == CMD_INSERT && task_queued[id])
            rpt.status = STAT_DUP_INSERT;
        else if (cmd == CMD_REMOVE && !task_queued[id])
            rpt.status = STAT_ABSENT;
        else if (cmd == CMD_INSERT)
        begin
            task_queued[id] = 1'b1;
            queued_count++;
            left = tk;
            if (!list_busy)
            begin
                list_first    = int'(id);
                list_busy     = 1'b1;
                link_next[id] = NO_LINK;
                link_prev[id] = NO_LINK;
            end
            else
            begin
                // walk past every entry due at or before the new wake-up time
                cur    = list_first;
                bef    = NO_LINK;
                walked = 0;
                while (walked < NTASK && cur != NO_LINK && left >= delta_of[cur])
                begin
                    left   = left - delta_of[cur];
                    bef    = cur;
                    cur    = link_next[cur];
                    walked++;
                end
                link_next[id] = cur;
                link_prev[id] = bef;
                if (cur != NO_LINK)
                begin
                    delta_of[cur]  = delta_of[cur] - left;
                    link_prev[cur] = int'(id);
                end
                if (bef != NO_LINK)
                    link_next[bef] = int'(id);
                else
                    list_first = int'(id);
            end
            delta_of[id] = left;
        end
        else
        begin
            // unlink; the successor inherits the removed delta
            task_queued[id] = 1'b0;
            queued_count--;
            nx = link_next[id];
            pv = link_prev[id];
            if (nx != NO_LINK)
            begin
                link_prev[nx] = pv;
                delta_of[nx]  = delta_of[nx] + delta_of[id];
            end
            if (pv != NO_LINK)
                link_next[pv] = nx;
            else
                list_first = (nx != NO_LINK) ? nx : 0;
            if (nx == NO_LINK && pv == NO_LINK)
            begin
                list_busy  = 1'b0;
                list_first = 0;
            end
            link_next[id] = NO_LINK;
            link_prev[id] = NO_LINK;
        end

        if (list_busy)
        begin
            rpt.head_valid = 1'b1;
            rpt.head_task  = list_first[TASK_ID_W-1:0];
            rpt.head_delta = delta_of[list_first];
        end
        else
        begin
            rpt.head_valid = 1'b0;
            rpt.head_task  = '0;
            rpt.head_delta = '0;
        end
        return rpt;
    endfunction

    // random task that is (or is not) in the list; scan from a random start
    function automatic logic [TASK_ID_W-1:0] pick_task(bit want_queued);
        int base;
        base = $urandom_range(0, NTASK - 1);
        for (int k = 0; k < NTASK; k++)
            if (task_queued[(base + k) % NTASK] == want_queued)
                return TASK_ID_W'((base + k) % NTASK);
        return TASK_ID_W'(base);
    endfunction

    // delay mix: full range, small values, extremes, and exact ties with a
    // queued entry's wake-up time
    function automatic logic [31:0] pick_ticks();
        int          sel;
        int          steps;
        int          cur;
        logic [31:0] wake;

        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 15);
            5:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            6, 7:    return $urandom_range(0, 5000);
            default:
            begin
                if (!list_busy)
                    return $urandom_range(0, 100);
                steps = $urandom_range(0, queued_count - 1);
                cur   = list_first;
                wake  = delta_of[cur];
                while (steps > 0 && link_next[cur] != NO_LINK)
                begin
                    cur  = link_next[cur];
                    wake = wake + delta_of[cur];
                    steps--;
                end
                return wake;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // item driver: optional gap, then hold the item until it is taken
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [TASK_ID_W-1:0] id,
                             input logic [TICKS_W-1:0] tk);
        if (sender_gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        task_id  <= id;
        ticks    <= tk;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        head_reports.push_back(apply_sleep_cmd(cmd, id, tk));
    endtask

    // Mostly well-formed traffic that keeps the list deep; a few items are
    // duplicate inserts or removes of absent tasks.
    task automatic send_random_op();
        int r;
        int ins_pct;

        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            if (queued_count > 0 && (queued_count == NTASK || $urandom_range(0, 1)))
                send_item(CMD_INSERT, pick_task(1), $urandom);
            else
                send_item(CMD_REMOVE, pick_task(0), $urandom);
        end
        else
        begin
            ins_pct = (queued_count < 8) ? 80 : ((queued_count > 26) ? 25 : 55);
            if (queued_count < NTASK &&
                (queued_count == 0 || $urandom_range(0, 99) < ins_pct))
                send_item(CMD_INSERT, pick_task(0), pick_ticks());
            else
                send_item(CMD_REMOVE, pick_task(1), $urandom);
        end
    endtask

    // stop offering and wait for every outstanding report
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (head_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic empty_list();
        while (queued_count > 0)
            send_item(CMD_REMOVE, pick_task(1), $urandom);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, ties, flagged commands, removal at head / middle / tail
    task automatic test_directed_cases();
        send_item(CMD_REMOVE, 5'd0,  32'h0);          // absent, list empty
        send_item(CMD_INSERT, 5'd0,  32'h0);
        send_item(CMD_INSERT, 5'd0,  32'hFFFF_FFFF);  // duplicate
        send_item(CMD_INSERT, 5'd31, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 5'd21, 32'h0);          // ties with head, goes after
        send_item(CMD_INSERT, 5'd10, 32'h5555_5555);
        send_item(CMD_INSERT, 5'd1,  32'hAAAA_AAAA);
        send_item(CMD_INSERT, 5'd2,  32'hAAAA_AAAA);  // tie in the middle
        send_item(CMD_INSERT, 5'd3,  32'hFFFF_FFFF);  // tie at the tail
        send_item(CMD_INSERT, 5'd4,  32'h1);
        send_item(CMD_REMOVE, 5'd0,  32'hFFFF_FFFF);  // head
        send_item(CMD_REMOVE, 5'd3,  32'h0);          // tail
        send_item(CMD_REMOVE, 5'd1,  32'h0);          // middle
        send_item(CMD_REMOVE, 5'd1,  32'h0);          // now absent
        send_item(CMD_INSERT, 5'd21, 32'h7);          // duplicate
        send_item(CMD_REMOVE, 5'd21, 32'h0);
        send_item(CMD_REMOVE, 5'd10, 32'h0);
        send_item(CMD_REMOVE, 5'd2,  32'h0);
        send_item(CMD_REMOVE, 5'd4,  32'h0);
        send_item(CMD_REMOVE, 5'd31, 32'h0);          // last one, list empty
        send_item(CMD_INSERT, 5'd31, 32'h0);
        send_item(CMD_REMOVE, 5'd31, 32'h0);
    endtask

    // full list; ascending wake-ups make every insert walk to the tail
    task automatic test_fill_and_empty();
        int step;

        empty_list();
        step = 1;
        while (queued_count < NTASK)
        begin
            send_item(CMD_INSERT, pick_task(0), step * 1000 + $urandom_range(0, 999));
            step++;
        end
        empty_list();
        while (queued_count < NTASK)
            send_item(CMD_INSERT, pick_task(0), pick_ticks());
        repeat (8)
            send_item(CMD_INSERT, pick_task(1), $urandom);   // all duplicates
        empty_list();
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        sender_gaps_on = 1'b0;
        hold_off_req   = 1'b1;
        repeat (40)
            send_random_op();
        sender_gaps_on = 1'b1;
    endtask

    // sender pauses until every report is back, then resumes
    task automatic test_drain_pause();
        repeat (30)
            send_random_op();
        wait_drained();
        repeat (30)
            send_random_op();
    endtask

    task automatic test_random_mix();
        repeat (1250)
            send_random_op();
    endtask

    // no idling on either side
    task automatic test_steady_stream();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        repeat (150)
            send_random_op();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : ready_driver
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (receiver_stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: each taken report against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : report_check
        head_report_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (head_reports.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected report: status %0d head_valid %0d task %0d delta %0d",
                         $time, status, head_valid, head_task, head_delta);
            end
            else
            begin
                want = head_reports.pop_front();
                if (status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (head_valid !== want.head_valid)
                begin
                    error_count++;
                    $display("%0t: head_valid expected %0d actual %0d",
                             $time, want.head_valid, head_valid);
                end
                if (head_task !== want.head_task)
                begin
                    error_count++;
                    $display("%0t: head_task expected %0d actual %0d",
                             $time, want.head_task, head_task);
                end
                if (head_delta !== want.head_delta)
                begin
                    error_count++;
                    $display("%0t: head_delta expected %0h actual %0h",
                             $time, want.head_delta, head_delta);
                end
            end
        end
    end

    // watchdog: too long without a handshake on either side means a hang
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;

        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("sleep_delta_queue_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NTASK; i++)
        begin
            link_next[i]   = NO_LINK;
            link_prev[i]   = NO_LINK;
            delta_of[i]    = '0;
            task_queued[i] = 1'b0;
        end
        list_first         = 0;
        list_busy          = 1'b0;
        queued_count       = 0;
        error_count        = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_off_req       = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_and_empty();
        test_output_backpressure();
        test_drain_pause();
        test_random_mix();
        test_steady_stream();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && head_reports.size() == 0)
            $display("sleep_delta_queue_core_tb passed");
        else
            $display("sleep_delta_queue_core_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
